@@ src/lzss_pkg.sv @@
// Shared constants and types for the LZSS stream decoder.
`timescale 1ns / 1ps

package lzss_pkg;

  // History ring geometry.
  localparam int HISTORY_SIZE = 4096;
  localparam int HIST_AW      = $clog2(HISTORY_SIZE);

  // Byte that every history entry reads as until it is first written.
  localparam logic [7:0] FILL_BYTE = 8'h20;

  // First history position that is written after reset.
  localparam logic [HIST_AW-1:0] START_POS = HIST_AW'(4078);

  // Shortest match, and the number of flags carried by one flag byte.
  localparam logic [4:0] MIN_MATCH  = 5'd3;
  localparam logic [3:0] FLAG_COUNT = 4'd8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,  // waiting for a compressed byte
    ST_LIT,   // literal byte held, waiting for the output slot
    ST_RD,    // issuing the history read for one match byte
    ST_DAT    // history data returned, waiting for the output slot
  } state_t;

endpackage

@@ src/lzss_stream_decoder.sv @@
// Top level of the LZSS stream decoder with a 4096-byte history ring.
//
//   Channel | Direction | Payload
//   --------+-----------+-----------------------------------------------
//   in_     | slave     | tdata[7:0] in_byte
//   out_    | master    | tdata[7:0] out_byte, tlast last_of_run
//
// A flag byte or the first byte of a pair is taken in ST_IDLE; a literal waits
// in ST_LIT for the output slot. The second byte of a pair starts a copy of 3
// to 18 bytes, each read from history (ST_RD), then held in ST_DAT for output.
// Reset does not sweep the history RAM: a fill counter tracks how many entries
// have been written since reset, and an unwritten entry reads as the fill byte.
// A stalled output holds its byte in the output register; the decoder waits.
`timescale 1ns / 1ps

module lzss_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  import lzss_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]         flag_bits_r, flag_bits_nxt;
  logic [3:0]         flags_left_r, flags_left_nxt;
  logic               awaiting_r, awaiting_nxt;
  logic [7:0]         low_pos_r, low_pos_nxt;
  logic [HIST_AW-1:0] write_pos_r, write_pos_nxt;
  logic [HIST_AW:0]   fill_cnt_r, fill_cnt_nxt;
  logic [HIST_AW-1:0] rd_pos_r, rd_pos_nxt;
  logic [4:0]         remain_r, remain_nxt;
  logic [7:0]         lit_r, lit_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_xfer;
  logic               slot_free;
  logic               ram_re;
  logic               ram_we;
  logic               emit;
  logic [7:0]         ram_rdata;
  logic [7:0]         emit_byte;
  logic [HIST_AW-1:0] rd_off;
  logic               is_flag_byte;
  logic               is_literal;
  logic               is_second;

  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_vld_r || out_tready;

  // Classification of the incoming byte from the parser state.
  assign is_flag_byte = (flags_left_r == 4'd0);
  assign is_literal   = !is_flag_byte && flag_bits_r[0];
  assign is_second    = !is_flag_byte && !flag_bits_r[0] && awaiting_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_literal) begin
          state_nxt = ST_LIT;
        end else if (in_xfer && is_second) begin
          state_nxt = ST_RD;
        end
      end
      ST_LIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_DAT;
      end
      ST_DAT: begin
        if (slot_free) begin
          state_nxt = (remain_r == 5'd0) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_LIT:  emit      = slot_free;
      ST_RD:   ram_re    = 1'b1;
      ST_DAT:  emit      = slot_free;
      default: in_tready = 1'b0;
    endcase
  end

  // Every emitted byte is also written back into the history.
  assign ram_we    = emit;
  assign emit_byte = (state_r == ST_LIT) ? lit_r : (rd_vld_r ? ram_rdata : FILL_BYTE);

  // An entry has been written once its distance from the start position
  // lies below the fill count.
  assign rd_off = rd_pos_r - START_POS;

  // Datapath next values.
  always_comb begin
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    awaiting_nxt   = awaiting_r;
    low_pos_nxt    = low_pos_r;
    write_pos_nxt  = write_pos_r;
    fill_cnt_nxt   = fill_cnt_r;
    rd_pos_nxt     = rd_pos_r;
    remain_nxt     = remain_r;
    lit_nxt        = lit_r;
    rd_vld_nxt     = rd_vld_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_vld_nxt    = out_vld_r && !out_tready;

    // Parse an accepted compressed byte.
    if (in_xfer) begin
      if (is_flag_byte) begin
        flag_bits_nxt  = in_tdata;
        flags_left_nxt = FLAG_COUNT;
      end else if (is_literal) begin
        lit_nxt = in_tdata;
      end else if (!awaiting_r) begin
        low_pos_nxt  = in_tdata;
        awaiting_nxt = 1'b1;
      end else begin
        rd_pos_nxt = {in_tdata[7:4], low_pos_r};
        remain_nxt = {1'b0, in_tdata[3:0]} + (MIN_MATCH - 5'd1);
      end
    end

    // Capture whether the entry being read was ever written.
    if (ram_re) begin
      rd_vld_nxt = ({1'b0, rd_off} < fill_cnt_r);
    end

    // Load the output register and advance the history.
    if (emit) begin
      out_vld_nxt   = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = (state_r == ST_LIT) || (remain_r == 5'd0);
      write_pos_nxt = write_pos_r + HIST_AW'(1);
      if (fill_cnt_r != (HIST_AW+1)'(HISTORY_SIZE)) begin
        fill_cnt_nxt = fill_cnt_r + (HIST_AW+1)'(1);
      end
      if (state_r == ST_DAT) begin
        rd_pos_nxt = rd_pos_r + HIST_AW'(1);
        remain_nxt = remain_r - 5'd1;
      end
      // The item is finished: consume its flag.
      if ((state_r == ST_LIT) || (remain_r == 5'd0)) begin
        flag_bits_nxt  = {1'b0, flag_bits_r[7:1]};
        flags_left_nxt = flags_left_r - 4'd1;
        if (state_r == ST_DAT) begin
          awaiting_nxt = 1'b0;
          low_pos_nxt  = 8'd0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flag_bits_r  <= 8'd0;
      flags_left_r <= 4'd0;
      awaiting_r   <= 1'b0;
      low_pos_r    <= 8'd0;
      write_pos_r  <= START_POS;
      fill_cnt_r   <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      awaiting_r   <= awaiting_nxt;
      low_pos_r    <= low_pos_nxt;
      write_pos_r  <= write_pos_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_pos_r   <= rd_pos_nxt;
    remain_r   <= remain_nxt;
    lit_r      <= lit_nxt;
    rd_vld_r   <= rd_vld_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // History ring.
  lzss_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos_r),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (rd_pos_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

@@ src/lzss_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/sv/tb_lzss_stream_decoder.sv @@
// Self-checking LZSS stream decoder bench: directed and random streams against a history model.
`timescale 1ns / 1ps

module tb_lzss_stream_decoder;
  import lzss_pkg::*;

  // Upper bound on the run, far above the slowest correct run of about 175 input
  // transfers, each followed by up to 18 output transfers under heavy receiver stalls.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 48;
  localparam int RANDOM_ITEMS  = 150;

  // One decompressed byte as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // History-ring model of the decoder and the queue of bytes it still owes.
  class lzss_scoreboard;
    logic [7:0]         history [HISTORY_SIZE];
    logic [HIST_AW-1:0] write_pos;
    logic [7:0]         flag_bits;
    logic [3:0]         flags_left;
    bit                 awaiting_second;
    logic [7:0]         low_pos_byte;
    out_beat_t          expected_q [$];
    int                 errors;
    int                 inputs_seen;
    int                 outputs_seen;
    int                 literal_count;
    int                 copy_count;

    function new();
      foreach (history[i]) history[i] = FILL_BYTE;
      write_pos       = START_POS;
      flag_bits       = '0;
      flags_left      = '0;
      awaiting_second = 1'b0;
      low_pos_byte    = '0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    // Emit one byte and append it to the history ring.
    function void emit_byte(logic [7:0] b, logic last);
      out_beat_t beat;
      beat.data = b;
      beat.last = last;
      expected_q.push_back(beat);
      history[write_pos] = b;
      write_pos = write_pos + 1'b1;
    endfunction

    // Advance the model by one accepted compressed byte.
    function void note_input(logic [7:0] b);
      logic [HIST_AW-1:0] pos;
      logic [4:0]         len;
      inputs_seen++;
      if (flags_left == '0) begin
        flag_bits  = b;
        flags_left = FLAG_COUNT;
        return;
      end
      if (flag_bits[0]) begin
        emit_byte(b, 1'b1);
        literal_count++;
      end else if (!awaiting_second) begin
        low_pos_byte    = b;
        awaiting_second = 1'b1;
        return;
      end else begin
        // Copies read one byte at a time, so overlapping runs see fresh bytes.
        pos = {b[7:4], low_pos_byte};
        len = 5'(b[3:0]) + MIN_MATCH;
        for (int k = 0; k < len; k++)
          emit_byte(history[pos + HIST_AW'(k)], (k + 1 == len));
        awaiting_second = 1'b0;
        low_pos_byte    = '0;
        copy_count++;
      end
      flag_bits  = flag_bits >> 1;
      flags_left = flags_left - 1'b1;
    endfunction

    // Compare one output transfer with the oldest expected byte.
    function void check_result(logic [7:0] data, logic last);
      out_beat_t want;
      outputs_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output byte 0x%02h last %0b", data, last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte 0x%02h, want 0x%02h", data, want.data));
      if (last !== want.last)
        report($sformatf("last_of_run %0b, want %0b (byte 0x%02h)", last, want.last, data));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  lzss_scoreboard sb = new();

  int         send_idle_pct;
  int         recv_idle_pct;
  bit         stall_req;
  int         stall_count;
  int         cycle_count;
  logic [3:0] pair_hi;

  lzss_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Offer one compressed byte, with random idle cycles first; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b);
    @(negedge clk);
  endtask

  // Pick the next byte from the model's parse state: random flag and literal bytes, and
  // pair positions mostly in recent history, with some fully random ones as noise.
  function automatic logic [7:0] next_byte();
    logic [HIST_AW-1:0] pos;
    if (sb.flags_left == '0)
      return 8'($urandom_range(255));
    if (sb.flag_bits[0])
      return 8'($urandom_range(255));
    if (!sb.awaiting_second) begin
      if ($urandom_range(99) < 20)
        pos = HIST_AW'($urandom_range(HISTORY_SIZE - 1));
      else
        pos = sb.write_pos - HIST_AW'($urandom_range(40, 1));
      pair_hi = pos[HIST_AW-1:8];
      return pos[7:0];
    end
    return {pair_hi, 4'($urandom_range(15))};
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_req && stall_count < HOLD_CYCLES) begin
      out_tready  <= 1'b0;
      stall_count <= stall_count + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every output transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[lzss_stream_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    // Literals at the byte extremes, then copies: a long overlapping run that wraps
    // the write position, the shortest copy, a read of never-written fill bytes,
    // a copy one byte behind the write position, and a read that wraps the ring.
    static logic [7:0] directed_bytes [20] = '{
      8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
      8'h00, 8'hEE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'h0D, 8'h0F, 8'hFE, 8'hF2
    };
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    stall_req     = 1'b0;
    stall_count   = 0;
    cycle_count   = 0;
    pair_hi       = '0;
    send_idle_pct = 35;
    recv_idle_pct = 81;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Random streams: receiver-heavy idling, sender-heavy idling, then only a long receiver hold-off.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 35; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stall_req     = 1'b1;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_byte(next_byte());
    end

    // Leave the stream cut off in the middle of a pair.
    while (!sb.awaiting_second) send_byte(next_byte());
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d output bytes never arrived", sb.expected_q.size()));

    $display("run: %0d compressed bytes in, %0d bytes out, %0d literals, %0d copies",
             sb.inputs_seen, sb.outputs_seen, sb.literal_count, sb.copy_count);
    $display("run: %0d mismatches in %0d cycles", sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("[lzss_stream_decoder] OK");
    end else begin
      $display("[lzss_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule
